[sv/adpcm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package adpcm_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned StepW   = 15;
  localparam int unsigned CodeW   = 4;

  localparam logic [StepW-1:0] StepInit = 15'd127;
  localparam logic [StepW-1:0] StepMin  = 15'd127;
  localparam logic [StepW-1:0] StepMax  = 15'd24576;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [StepW-1:0]          step_t;
  typedef logic [CodeW-1:0]          code_t;

  typedef struct packed {
    sample_t pred;
    step_t   step;
  } nib_state_t;

  function automatic logic [7:0] step_factor(input logic [2:0] mag);
    logic [7:0] f;
    case (mag)
      3'd4:    f = 8'd77;
      3'd5:    f = 8'd102;
      3'd6:    f = 8'd128;
      3'd7:    f = 8'd153;
      default: f = 8'd57;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

[sv/adpcm_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface adpcm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] adpcm_byte;
  logic       voice_start;

  modport source (output valid, output adpcm_byte, output voice_start, input ready);
  modport sink   (input valid, input adpcm_byte, input voice_start, output ready);
endinterface

`default_nettype wire

[sv/adpcm_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface adpcm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pcm_sample;
  logic               pair_last;

  modport source (output valid, output pcm_sample, output pair_last, input ready);
  modport sink   (input valid, input pcm_sample, input pair_last, output ready);
endinterface

`default_nettype wire

[sv/adpcm_nibble.sv]
`timescale 1ns / 1ps
`default_nettype none

module adpcm_nibble
  import adpcm_pkg::*;
(
  input  code_t      code,
  input  nib_state_t cur,
  output nib_state_t nxt
);

  logic [3:0]         odd;
  logic [18:0]        scaled;
  logic [15:0]        delta;
  logic signed [17:0] pred_ext;
  logic signed [17:0] delta_ext;
  logic signed [17:0] sum;
  logic [22:0]        prod;
  logic [16:0]        step_raw;

  always_comb begin
    odd       = {code[2:0], 1'b1};
    scaled    = 19'(odd) * 19'(cur.step);
    delta     = scaled[18:3];
    pred_ext  = {{2{cur.pred[15]}}, cur.pred};
    delta_ext = $signed({2'b00, delta});
    sum       = code[3] ? (pred_ext - delta_ext) : (pred_ext + delta_ext);
    if (sum > 18'sd32767) begin
      nxt.pred = 16'sh7fff;
    end else if (sum < -18'sd32768) begin
      nxt.pred = 16'sh8000;
    end else begin
      nxt.pred = sum[15:0];
    end

    prod     = 23'(cur.step) * 23'(step_factor(code[2:0]));
    step_raw = prod[22:6];
    if (step_raw < 17'(StepMin)) begin
      nxt.step = StepMin;
    end else if (step_raw > 17'(StepMax)) begin
      nxt.step = StepMax;
    end else begin
      nxt.step = step_raw[14:0];
    end
  end

endmodule

`default_nettype wire

[sv/adpcm_nibble_decoder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  payload                          beats
// in_chan   in   adpcm_byte[7:0], voice_start     one per byte
// out_chan  out  pcm_sample[15:0] s, pair_last    two per byte, high nibble first
//
// The nibble datapath decodes one nibble a cycle while the output is not stalled, since
// each nibble needs the predictor and step left by the one before.
// A byte beat lands in the input register; its first sample is then decoded into the output register.
// Reset (rst_n low, synchronous) clears predictor to 0 and step to 127.
// A stalled result holds in the output register and the datapath waits; the
// next byte is taken in the cycle the low nibble is decoded.

module adpcm_nibble_decoder_unit
  import adpcm_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  adpcm_in_if.sink          in_chan,
  adpcm_out_if.source       out_chan
);

  logic       item_vld_r, item_vld_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       vs_r, vs_nxt;
  logic       phase_r, phase_nxt;
  sample_t    pred_r, pred_nxt;
  step_t      step_r, step_nxt;
  logic       out_vld_r, out_vld_nxt;
  sample_t    sample_r, sample_nxt;
  logic       last_r, last_nxt;

  logic       advance;
  logic       in_fire;
  code_t      code;
  nib_state_t cur_st;
  nib_state_t new_st;

  assign advance        = item_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready  = !item_vld_r || (advance && phase_r);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign code           = phase_r ? byte_r[3:0] : byte_r[7:4];

  always_comb begin
    if (!phase_r && vs_r) begin
      cur_st.pred = '0;
      cur_st.step = StepInit;
    end else begin
      cur_st.pred = pred_r;
      cur_st.step = step_r;
    end
  end

  adpcm_nibble u_nibble (
    .code (code),
    .cur  (cur_st),
    .nxt  (new_st)
  );

  always_comb begin
    item_vld_nxt = item_vld_r;
    byte_nxt     = byte_r;
    vs_nxt       = vs_r;
    phase_nxt    = phase_r;
    pred_nxt     = pred_r;
    step_nxt     = step_r;
    out_vld_nxt  = out_vld_r;
    sample_nxt   = sample_r;
    last_nxt     = last_r;

    if (advance) begin
      pred_nxt    = new_st.pred;
      step_nxt    = new_st.step;
      phase_nxt   = !phase_r;
      out_vld_nxt = 1'b1;
      sample_nxt  = new_st.pred;
      last_nxt    = phase_r;
      if (phase_r) begin
        item_vld_nxt = 1'b0;
      end
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end

    if (in_fire) begin
      item_vld_nxt = 1'b1;
      byte_nxt     = in_chan.adpcm_byte;
      vs_nxt       = in_chan.voice_start;
      phase_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      phase_r    <= 1'b0;
      pred_r     <= '0;
      step_r     <= StepInit;
      out_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      phase_r    <= phase_nxt;
      pred_r     <= pred_nxt;
      step_r     <= step_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    byte_r   <= byte_nxt;
    vs_r     <= vs_nxt;
    sample_r <= sample_nxt;
    last_r   <= last_nxt;
  end

  assign out_chan.valid      = out_vld_r;
  assign out_chan.pcm_sample = sample_r;
  assign out_chan.pair_last  = last_r;

  a_fire_starts_high: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (item_vld_r && !phase_r))
    else $error("byte beat did not start at the high nibble");

  a_high_then_low: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !phase_r) |=> (item_vld_r && phase_r && out_vld_r && !last_r))
    else $error("high nibble not followed by low nibble");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r >= StepMin) && (step_r <= StepMax))
    else $error("step out of range");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !item_vld_r |-> in_chan.ready)
    else $error("empty input register not ready");

endmodule

`default_nettype wire
